// ===== hdl/lrk_pkg.sv =====
// Shared types, constants and saturation helpers for the ladder lowpass filter.
`timescale 1ns / 1ps

package lrk_pkg;

    typedef logic signed [31:0] t_q;
    typedef logic signed [33:0] t_mop;
    typedef logic signed [67:0] t_prod;
    typedef logic signed [35:0] t_acc;

    // Configuration register indexes.
    localparam logic [1:0] REG_SAT_LEVEL  = 2'd0;
    localparam logic [1:0] REG_SAT_RECIP  = 2'd1;
    localparam logic [1:0] REG_STEP_SIZE  = 2'd2;
    localparam logic [1:0] REG_OVERSAMPLE = 2'd3;

    localparam logic [30:0] RST_SAT_LEVEL  = 31'd50331648;
    localparam logic [30:0] RST_SAT_RECIP  = 31'd5592405;
    localparam logic [31:0] RST_STEP_SIZE  = 32'd44739;
    localparam logic [3:0]  RST_OVERSAMPLE = 4'd2;

    localparam logic [3:0]  MAX_OVERSAMPLE = 4'd8;

    // 2*pi as unsigned Q3.29, one third and one as Q8.24.
    localparam logic [31:0]        TWO_PI_Q29 = 32'd3373259426;
    localparam logic signed [33:0] Q_THIRD    = 34'sd5592405;
    localparam logic signed [31:0] Q_ONE      = 32'sd16777216;
    // (2^34 + 2) / 3: floor(x * DIV3_MUL / 2^34) equals floor(x / 3) for x below 2^33.
    localparam logic signed [33:0] DIV3_MUL   = 34'sd5726623062;

    localparam logic signed [31:0] Q_MAX = 32'sh7FFFFFFF;
    localparam logic signed [31:0] Q_MIN = 32'sh80000000;

    function automatic t_acc f_sx36(input t_q v);
        return {{4{v[31]}}, v};
    endfunction

    function automatic t_q f_sat36(input t_acc v);
        if (v > 36'sd2147483647) begin
            return Q_MAX;
        end else if (v < -36'sd2147483648) begin
            return Q_MIN;
        end else begin
            return v[31:0];
        end
    endfunction

endpackage

// ===== hdl/lrk_mul.sv =====
// Shared signed multiplier with product register and Q8.24 round-and-saturate.
`timescale 1ns / 1ps

module lrk_mul
    import lrk_pkg::*;
(
    input  logic  i_clk,
    input  t_mop  i_a,
    input  t_mop  i_b,
    output t_prod o_prod,
    output t_q    o_rq
);

    t_prod              r_prod;
    logic signed [67:0] w_adj;
    logic signed [43:0] w_sh;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    // Round to nearest with ties away from zero: negative values get one less.
    always_comb begin
        w_adj = r_prod + (r_prod[67] ? 68'sd8388607 : 68'sd8388608);
        w_sh  = w_adj[67:24];
        if (w_sh > 44'sd2147483647) begin
            o_rq = Q_MAX;
        end else if (w_sh < -44'sd2147483648) begin
            o_rq = Q_MIN;
        end else begin
            o_rq = w_sh[31:0];
        end
    end

    assign o_prod = r_prod;

endmodule

// ===== hdl/ladder_lowpass_rk4_filter.sv =====
// Top level of the four-pole nonlinear ladder lowpass filter with RK4 solver.
`timescale 1ns / 1ps
//
// Usage: one input transaction on the s channel carries an audio sample, the
// cutoff frequency, the resonance and five mix gains. The block then runs
// oversample_count fourth-order Runge-Kutta steps of the ladder on one shared
// 34x34 multiplier and returns one output transaction on the m channel: the
// gain-weighted mix, the fourth pole and the second pole.
// Every multiply is issued and then rounded and written back, and the
// sequencer runs them one after another, so the multiplier sets the rate.
// The oversample count is limited to 8. o_s_tready is high only while the
// block is idle; the next transaction is taken as soon as the previous result
// sits in the output register, even if that result has not been taken yet.
// If the receiver stalls, a finished result waits in the sequencer until the
// output register frees up. Reset (synchronous, active low) clears the pole
// states, the handshakes and loads the default configuration. Configuration
// writes are taken at any clock edge with i_cfg_we high and should only be
// made while the block is idle.

module ladder_lowpass_rk4_filter
    import lrk_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // sample_in[31:0], frequency[55:32], resonance[87:56], input_gain[119:88],
    // pole1_gain[151:120], pole2_gain[183:152], pole3_gain[215:184],
    // pole4_gain[247:216], zero fill[255:248]
    input  logic [255:0] i_s_tdata,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // mix_out[31:0], four_pole_out[63:32], two_pole_out[95:64]
    output logic [95:0]  o_m_tdata,
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_addr,
    input  logic [31:0]  i_cfg_wdata
);

    // Sequencer states. Every state but idle, start-of-step and output is
    // one multiply of two phases.
    localparam logic [4:0] ST_IDLE = 5'd0;
    localparam logic [4:0] ST_K1   = 5'd1;
    localparam logic [4:0] ST_K2   = 5'd2;
    localparam logic [4:0] ST_K3   = 5'd3;
    localparam logic [4:0] ST_SS   = 5'd4;
    localparam logic [4:0] ST_R    = 5'd5;
    localparam logic [4:0] ST_CL1  = 5'd6;
    localparam logic [4:0] ST_CL2  = 5'd7;
    localparam logic [4:0] ST_CL3  = 5'd8;
    localparam logic [4:0] ST_CL4  = 5'd9;
    localparam logic [4:0] ST_CL5  = 5'd10;
    localparam logic [4:0] ST_E    = 5'd11;
    localparam logic [4:0] ST_D    = 5'd12;
    localparam logic [4:0] ST_MX   = 5'd13;
    localparam logic [4:0] ST_OUT  = 5'd14;

    // Configuration.
    logic [30:0] r_sat_level;
    logic [30:0] r_sat_recip;
    logic [31:0] r_step_size;
    logic [3:0]  r_oversample;

    // Sequencer.
    logic [4:0] r_state;
    logic       r_ph;
    logic [2:0] r_idx;
    logic [1:0] r_stg;
    logic [2:0] r_step;
    logic       r_ret_pole;

    // Sample context.
    t_q          r_x;
    logic [23:0] r_freq;
    t_q          r_res;
    t_q          r_gain [5];
    logic [55:0] r_p;
    logic [59:0] r_kh;
    t_q          r_k;

    // Solver values.
    t_q   r_pole [4];
    t_q   r_tmp  [4];
    t_acc r_acc  [4];
    t_q   r_cx;
    t_q   r_cy;
    t_q   r_v;
    t_q   r_t;
    t_q   r_prev;
    t_q   r_mix;

    logic        r_ovalid;
    logic [95:0] r_odata;

    // Datapath wires.
    t_mop         w_a;
    t_mop         w_b;
    t_prod        w_prod;
    t_q           w_rq;
    logic         w_is_mul;
    logic         w_accept;
    logic         w_out_free;
    logic [3:0]   w_nsteps;
    logic [88:0]  w_ksum;
    logic [43:0]  w_kq;
    t_q           w_k;
    t_q           w_clamp;
    t_q           w_diff;
    t_acc         w_amag;
    logic [35:0]  w_m;
    t_acc         w_q;
    t_acc         w_e;
    t_acc         w_half;
    t_q           w_mix_pole;
    logic [1:0]   w_i2;

    lrk_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_a),
        .i_b    (w_b),
        .o_prod (w_prod),
        .o_rq   (w_rq)
    );

    assign w_accept   = i_s_tvalid && o_s_tready;
    assign o_s_tready = (r_state == ST_IDLE);
    assign w_out_free = !r_ovalid || i_m_tready;
    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_odata;
    assign w_i2       = r_idx[1:0];

    assign w_is_mul = !(r_state inside {ST_IDLE, ST_SS, ST_OUT});

    // Oversample zero runs no step; counts above the limit are held there.
    assign w_nsteps = (r_oversample > MAX_OVERSAMPLE) ? MAX_OVERSAMPLE : r_oversample;

    always_comb begin
        // Step coefficient: (p_hi * C) << 28 plus p_lo * C, rounded at bit 45.
        w_ksum = {1'b0, r_kh, 28'd0} + {29'd0, w_prod[59:0]} + (89'd1 << 44);
        w_kq   = w_ksum[88:45];
        w_k    = (w_kq > 44'd2147483647) ? Q_MAX : w_kq[31:0];

        if (w_rq > Q_ONE) begin
            w_clamp = Q_ONE;
        end else if (w_rq < -Q_ONE) begin
            w_clamp = -Q_ONE;
        end else begin
            w_clamp = w_rq;
        end

        w_diff = f_sat36(f_sx36(r_prev) - f_sx36(r_cy));

        // Weighted RK4 sum divided by six: magnitude plus three, halve, then
        // divide by three through the reciprocal multiply.
        w_amag = r_acc[w_i2][35] ? -r_acc[w_i2] : r_acc[w_i2];
        w_m    = w_amag + 36'd3;
        w_q    = {2'b00, w_prod[67:34]};

        w_e    = f_sx36(w_rq);
        w_half = w_rq[31] ? (w_e >>> 1) : ((w_e + 36'sd1) >>> 1);

        w_mix_pole = r_pole[2'(r_idx - 3'd1)];
    end

    // Operand selection for the shared multiplier.
    always_comb begin
        w_a = '0;
        w_b = '0;
        case (r_state)
            ST_K1: begin
                w_a = {10'd0, r_freq};
                w_b = {2'd0, r_step_size};
            end
            ST_K2: begin
                w_a = {6'd0, r_p[55:28]};
                w_b = {2'd0, TWO_PI_Q29};
            end
            ST_K3: begin
                w_a = {6'd0, r_p[27:0]};
                w_b = {2'd0, TWO_PI_Q29};
            end
            ST_R: begin
                w_a = {{2{r_res[31]}}, r_res};
                w_b = {{2{r_tmp[3][31]}}, r_tmp[3]};
            end
            ST_CL1: begin
                w_a = {{2{r_cx[31]}}, r_cx};
                w_b = {3'd0, r_sat_recip};
            end
            ST_CL2: begin
                w_a = {{2{r_v[31]}}, r_v};
                w_b = {{2{r_v[31]}}, r_v};
            end
            ST_CL3: begin
                w_a = {{2{r_t[31]}}, r_t};
                w_b = {{2{r_v[31]}}, r_v};
            end
            ST_CL4: begin
                w_a = {{2{r_t[31]}}, r_t};
                w_b = Q_THIRD;
            end
            ST_CL5: begin
                w_a = {3'd0, r_sat_level};
                w_b = {{2{r_t[31]}}, r_t};
            end
            ST_E: begin
                w_a = {{2{r_k[31]}}, r_k};
                w_b = {{2{w_diff[31]}}, w_diff};
            end
            ST_D: begin
                w_a = {1'b0, w_m[33:1]};
                w_b = DIV3_MUL;
            end
            ST_MX: begin
                if (r_idx == 3'd0) begin
                    w_a = {{2{r_x[31]}}, r_x};
                end else begin
                    w_a = {{2{w_mix_pole[31]}}, w_mix_pole};
                end
                w_b = {{2{r_gain[r_idx][31]}}, r_gain[r_idx]};
            end
            default: begin
                w_a = '0;
                w_b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_ph         <= 1'b0;
            r_ovalid     <= 1'b0;
            r_sat_level  <= RST_SAT_LEVEL;
            r_sat_recip  <= RST_SAT_RECIP;
            r_step_size  <= RST_STEP_SIZE;
            r_oversample <= RST_OVERSAMPLE;
            for (int i = 0; i < 4; i++) begin
                r_pole[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_SAT_LEVEL:  r_sat_level  <= i_cfg_wdata[30:0];
                    REG_SAT_RECIP:  r_sat_recip  <= i_cfg_wdata[30:0];
                    REG_STEP_SIZE:  r_step_size  <= i_cfg_wdata;
                    REG_OVERSAMPLE: r_oversample <= i_cfg_wdata[3:0];
                    default: begin
                    end
                endcase
            end

            // The output state reloads the register itself when it is free.
            if (r_ovalid && i_m_tready && r_state != ST_OUT) begin
                r_ovalid <= 1'b0;
            end

            if (w_is_mul && !r_ph) begin
                r_ph <= 1'b1;
            end else begin
                r_ph <= 1'b0;
                case (r_state)
                    ST_IDLE: begin
                        if (w_accept) begin
                            r_x       <= i_s_tdata[31:0];
                            r_freq    <= i_s_tdata[55:32];
                            // Negative resonance counts as zero.
                            r_res     <= i_s_tdata[87] ? '0 : i_s_tdata[87:56];
                            r_gain[0] <= i_s_tdata[119:88];
                            r_gain[1] <= i_s_tdata[151:120];
                            r_gain[2] <= i_s_tdata[183:152];
                            r_gain[3] <= i_s_tdata[215:184];
                            r_gain[4] <= i_s_tdata[247:216];
                            r_state   <= ST_K1;
                        end
                    end
                    ST_K1: begin
                        r_p     <= w_prod[55:0];
                        r_state <= ST_K2;
                    end
                    ST_K2: begin
                        r_kh    <= w_prod[59:0];
                        r_state <= ST_K3;
                    end
                    ST_K3: begin
                        r_k    <= w_k;
                        r_step <= 3'd0;
                        r_idx  <= 3'd0;
                        r_state <= (w_nsteps == 4'd0) ? ST_MX : ST_SS;
                    end
                    ST_SS: begin
                        for (int i = 0; i < 4; i++) begin
                            r_tmp[i] <= r_pole[i];
                            r_acc[i] <= '0;
                        end
                        r_stg   <= 2'd0;
                        r_state <= ST_R;
                    end
                    ST_R: begin
                        r_cx       <= f_sat36(f_sx36(r_x) - f_sx36(w_rq));
                        r_ret_pole <= 1'b0;
                        r_state    <= ST_CL1;
                    end
                    ST_CL1: begin
                        r_v     <= w_clamp;
                        r_state <= ST_CL2;
                    end
                    ST_CL2: begin
                        r_t     <= w_rq;
                        r_state <= ST_CL3;
                    end
                    ST_CL3: begin
                        r_t     <= w_rq;
                        r_state <= ST_CL4;
                    end
                    ST_CL4: begin
                        r_t     <= f_sat36(f_sx36(r_v) - f_sx36(w_rq));
                        r_state <= ST_CL5;
                    end
                    ST_CL5: begin
                        r_cy <= w_rq;
                        if (!r_ret_pole) begin
                            // Clipped drive becomes the source of the first pole.
                            r_prev     <= w_rq;
                            r_idx      <= 3'd0;
                            r_cx       <= r_tmp[0];
                            r_ret_pole <= 1'b1;
                            r_state    <= ST_CL1;
                        end else begin
                            r_state <= ST_E;
                        end
                    end
                    ST_E: begin
                        if (r_stg inside {2'd0, 2'd3}) begin
                            r_acc[w_i2] <= r_acc[w_i2] + w_e;
                        end else begin
                            r_acc[w_i2] <= r_acc[w_i2] + (w_e <<< 1);
                        end
                        if (r_stg != 2'd3) begin
                            r_tmp[w_i2] <= f_sat36(f_sx36(r_pole[w_i2]) + w_half);
                        end
                        r_prev <= r_cy;
                        if (r_idx != 3'd3) begin
                            r_idx   <= r_idx + 3'd1;
                            r_cx    <= r_tmp[2'(r_idx + 3'd1)];
                            r_state <= ST_CL1;
                        end else if (r_stg != 2'd3) begin
                            r_stg   <= r_stg + 2'd1;
                            r_state <= ST_R;
                        end else begin
                            r_idx   <= 3'd0;
                            r_state <= ST_D;
                        end
                    end
                    ST_D: begin
                        r_pole[w_i2] <= f_sat36(f_sx36(r_pole[w_i2]) +
                                                (r_acc[w_i2][35] ? -w_q : w_q));
                        if (r_idx != 3'd3) begin
                            r_idx <= r_idx + 3'd1;
                        end else if ({1'b0, r_step} + 4'd1 == w_nsteps) begin
                            r_idx   <= 3'd0;
                            r_state <= ST_MX;
                        end else begin
                            r_step  <= r_step + 3'd1;
                            r_state <= ST_SS;
                        end
                    end
                    ST_MX: begin
                        if (r_idx == 3'd0) begin
                            r_mix <= w_rq;
                        end else begin
                            r_mix <= f_sat36(f_sx36(r_mix) + f_sx36(w_rq));
                        end
                        if (r_idx != 3'd4) begin
                            r_idx <= r_idx + 3'd1;
                        end else begin
                            r_state <= ST_OUT;
                        end
                    end
                    ST_OUT: begin
                        if (w_out_free) begin
                            r_odata  <= {r_pole[1], r_pole[3], r_mix};
                            r_ovalid <= 1'b1;
                            r_state  <= ST_IDLE;
                        end
                    end
                    default: begin
                        r_state <= ST_IDLE;
                    end
                endcase
            end
        end
    end

`ifndef SYNTHESIS
    // An accepted transaction keeps the input closed on the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !o_s_tready)
        else $error("input ready while a sample is in work");

    // A new result only appears out of the output state.
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(r_state == ST_OUT))
        else $error("result presented outside the output state");

    // The write-back phase only follows a multiply issue.
    a_phase_in_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ph |-> w_is_mul)
        else $error("write-back phase outside a multiply state");
`endif

endmodule

// ===== verif/tb_ladder_lowpass_rk4_filter.sv =====
// Self-checking testbench for the ladder lowpass filter with RK4 solver.
`timescale 1ns / 1ps

module tb_ladder_lowpass_rk4_filter;
    import lrk_pkg::*;

    // One input transaction, packed so that the last declared field, the sample, sits in the lowest bits.
    typedef struct packed {
        logic signed [31:0] g4;
        logic signed [31:0] g3;
        logic signed [31:0] g2;
        logic signed [31:0] g1;
        logic signed [31:0] g0;
        logic signed [31:0] res;
        logic [23:0]        freq;
        logic signed [31:0] samp;
    } t_audio_in;

    typedef struct {
        logic signed [31:0] mix;
        logic signed [31:0] p4;
        logic signed [31:0] p2;
    } t_filter_out;

    localparam longint LIMIT_CYCLES = 3000000;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_s_tvalid;
    logic         o_s_tready;
    // sample_in, frequency, resonance, input_gain, pole1_gain .. pole4_gain, zero fill
    logic [255:0] i_s_tdata;
    logic         o_m_tvalid;
    logic         i_m_tready;
    // mix_out, four_pole_out, two_pole_out
    logic [95:0]  o_m_tdata;
    logic         i_cfg_we;
    logic [1:0]   i_cfg_addr;
    logic [31:0]  i_cfg_wdata;

    ladder_lowpass_rk4_filter i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // Mirror of the configuration and of the four pole states.
    longint cfg_level;
    longint cfg_recip;
    longint cfg_step;
    longint cfg_osr;
    longint poles [4];

    t_audio_in   pending_samples [$];
    t_filter_out expected_outputs [$];

    int     idle_pct_in;
    int     stall_pct_out;
    int     n_errors;
    int     n_checked;
    int     n_sent;
    longint n_cycles;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // ---------------------------------------------------------------------
    // Fixed-point arithmetic of the filter, computed on 64 and 128 bits.
    // ---------------------------------------------------------------------
    function automatic longint sat_q(input longint v);
        if (v > 64'sd2147483647) begin
            return 64'sd2147483647;
        end else if (v < -64'sd2147483648) begin
            return -64'sd2147483648;
        end
        return v;
    endfunction

    // Exact product, rounded half away from zero at bit sh, saturated to 32 bits.
    function automatic longint mul_round(input longint a, input longint b, input int sh);
        logic         neg;
        logic [127:0] p;
        logic [127:0] lim;
        neg = (a < 0) != (b < 0);
        p   = (a < 0 ? 128'(-a) : 128'(a)) * (b < 0 ? 128'(-b) : 128'(b));
        p   = (p + (128'd1 << (sh - 1))) >> sh;
        lim = neg ? 128'd2147483648 : 128'd2147483647;
        if (p > lim) begin
            p = lim;
        end
        return neg ? -longint'(p) : longint'(p);
    endfunction

    function automatic longint mulq(input longint a, input longint b);
        return mul_round(a, b, 24);
    endfunction

    function automatic longint div_near(input longint v, input longint d);
        return v >= 0 ? (v + d / 2) / d : (v - d / 2) / d;
    endfunction

    // Cubic soft clip: level * (v - v^3/3), v = x / level limited to [-1, 1].
    function automatic longint soft_clip(input longint x);
        longint v;
        longint v3;
        v = mulq(x, cfg_recip);
        if (v > longint'(Q_ONE)) begin
            v = Q_ONE;
        end
        if (v < -longint'(Q_ONE)) begin
            v = -longint'(Q_ONE);
        end
        v3 = mulq(mulq(v, v), v);
        return mulq(cfg_level, sat_q(v - mulq(v3, longint'(Q_THIRD))));
    endfunction

    // Derivative increments of the four stages for one RK4 evaluation.
    function automatic void stage_slopes(input longint x, input longint k, input longint res,
                                         input longint st [4], output longint e [4]);
        longint s [4];
        longint drive;
        for (int i = 0; i < 4; i++) begin
            s[i] = soft_clip(st[i]);
        end
        drive = soft_clip(sat_q(x - mulq(res, st[3])));
        e[0] = mulq(k, sat_q(drive - s[0]));
        for (int i = 1; i < 4; i++) begin
            e[i] = mulq(k, sat_q(s[i - 1] - s[i]));
        end
    endfunction

    function automatic void ladder_rk4_step(input longint x, input longint k, input longint res);
        longint e1 [4];
        longint e2 [4];
        longint e3 [4];
        longint e4 [4];
        longint mid [4];
        stage_slopes(x, k, res, poles, e1);
        for (int i = 0; i < 4; i++) mid[i] = sat_q(poles[i] + div_near(e1[i], 2));
        stage_slopes(x, k, res, mid, e2);
        for (int i = 0; i < 4; i++) mid[i] = sat_q(poles[i] + div_near(e2[i], 2));
        stage_slopes(x, k, res, mid, e3);
        for (int i = 0; i < 4; i++) mid[i] = sat_q(poles[i] + div_near(e3[i], 2));
        stage_slopes(x, k, res, mid, e4);
        for (int i = 0; i < 4; i++) begin
            poles[i] = sat_q(poles[i]
                             + div_near(e1[i] + 2 * e2[i] + 2 * e3[i] + e4[i], 6));
        end
    endfunction

    // Advances the pole states for one accepted sample and queues the expected output.
    function automatic void filter_sample(input t_audio_in it);
        longint      x;
        longint      res;
        longint      k;
        longint      steps;
        longint      gains [4];
        t_filter_out o;
        x   = it.samp;
        res = it.res < 0 ? 0 : it.res;
        k   = mul_round(longint'(it.freq) * cfg_step, longint'(TWO_PI_Q29), 45);
        steps = cfg_osr > longint'(MAX_OVERSAMPLE) ? longint'(MAX_OVERSAMPLE) : cfg_osr;
        for (longint j = 0; j < steps; j++) begin
            ladder_rk4_step(x, k, res);
        end
        gains = '{it.g1, it.g2, it.g3, it.g4};
        o.mix = mulq(x, it.g0);
        for (int i = 0; i < 4; i++) begin
            o.mix = sat_q(o.mix + mulq(poles[i], gains[i]));
        end
        o.p4 = poles[3];
        o.p2 = poles[1];
        expected_outputs.push_back(o);
    endfunction

    // ---------------------------------------------------------------------
    // Driver: presents queued samples; a presented transaction stays until taken.
    // ---------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                filter_sample(pending_samples.pop_front());
                n_sent++;
            end
            if (i_s_tvalid && !o_s_tready) begin
                i_s_tvalid <= 1'b1;
            end else if (pending_samples.size() > 0
                         && $urandom_range(99) >= idle_pct_in) begin
                i_s_tvalid <= 1'b1;
                i_s_tdata  <= {8'd0, pending_samples[0]};
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s on output %0d: got %h, expected %h", what, n_checked, got, want);
        n_errors++;
    endtask

    // Monitor: compares each output transaction with the oldest expectation.
    always @(posedge i_clk) begin
        t_filter_out want;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                if (expected_outputs.size() == 0) begin
                    report_mismatch("unexpected transaction", o_m_tdata[31:0], 32'd0);
                end else begin
                    want = expected_outputs.pop_front();
                    if (o_m_tdata[31:0] !== want.mix)
                        report_mismatch("mix_out", o_m_tdata[31:0], want.mix);
                    if (o_m_tdata[63:32] !== want.p4)
                        report_mismatch("four_pole_out", o_m_tdata[63:32], want.p4);
                    if (o_m_tdata[95:64] !== want.p2)
                        report_mismatch("two_pole_out", o_m_tdata[95:64], want.p2);
                end
                n_checked++;
            end
            i_m_tready <= $urandom_range(99) >= stall_pct_out;
        end
    end

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles > LIMIT_CYCLES) begin
            $display("Timeout with %0d outputs outstanding", expected_outputs.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------------
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= value;
        case (idx)
            REG_SAT_LEVEL:  cfg_level = value & 32'h7FFFFFFF;
            REG_SAT_RECIP:  cfg_recip = value & 32'h7FFFFFFF;
            REG_STEP_SIZE:  cfg_step  = value;
            REG_OVERSAMPLE: cfg_osr   = value & 32'hF;
            default: begin
            end
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Audio-like values most of the time, raw 32-bit patterns now and then.
    function automatic logic [31:0] rand_q();
        case ($urandom_range(5))
            0:       return $urandom;
            1:       return $urandom_range(1) ? 32'h7FFFFFFF : 32'h80000000;
            default: return 32'($signed($urandom_range(200000000)) - 100000000);
        endcase
    endfunction

    function automatic t_audio_in rand_sample();
        t_audio_in it;
        it.samp = rand_q();
        case ($urandom_range(3))
            0:       it.freq = 24'($urandom);
            default: it.freq = 24'($urandom_range(2560000, 2560));
        endcase
        it.res = $urandom_range(2) == 0 ? rand_q() : 32'($urandom_range(80000000));
        it.g0  = rand_q();
        it.g1  = rand_q();
        it.g2  = rand_q();
        it.g3  = rand_q();
        it.g4  = rand_q();
        return it;
    endfunction

    task automatic drain();
        while (pending_samples.size() > 0 || expected_outputs.size() > 0 || i_s_tvalid)
            @(posedge i_clk);
    endtask

    task automatic run_phase(input int n_items, input int mode);
        idle_pct_in   = (mode == 1 || mode == 3) ? (mode == 1 ? 83 : 7) : 0;
        stall_pct_out = (mode == 2 || mode == 3) ? (mode == 2 ? 83 : 7) : 0;
        repeat (n_items) pending_samples.push_back(rand_sample());
        drain();
    endtask

    initial begin
        t_audio_in d;
        i_rst_n     = 1'b0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_m_tready  = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_addr  = '0;
        i_cfg_wdata = '0;
        n_errors = 0;
        n_checked = 0;
        n_sent = 0;
        n_cycles = 0;
        idle_pct_in = 0;
        stall_pct_out = 0;
        cfg_level = RST_SAT_LEVEL;
        cfg_recip = RST_SAT_RECIP;
        cfg_step  = RST_STEP_SIZE;
        cfg_osr   = RST_OVERSAMPLE;
        poles = '{0, 0, 0, 0};
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed samples under the reset configuration: field extremes,
        // negative resonance, zero and full-scale cutoff, saturating mixes.
        d = '{g4: 32'h7FFFFFFF, g3: 32'h80000000, g2: 32'h01000000, g1: 32'h01000000,
              g0: 32'h01000000, res: 32'h02000000, freq: 24'd256000, samp: 32'h7FFFFFFF};
        pending_samples.push_back(d);
        d.samp = 32'h80000000;
        pending_samples.push_back(d);
        d.res = 32'h80000000;
        pending_samples.push_back(d);
        d.res = 32'h7FFFFFFF;
        d.freq = 24'hFFFFFF;
        pending_samples.push_back(d);
        d.freq = 24'd0;
        d.samp = 32'd0;
        pending_samples.push_back(d);
        d = '{g4: 32'h7FFFFFFF, g3: 32'h7FFFFFFF, g2: 32'h7FFFFFFF, g1: 32'h7FFFFFFF,
              g0: 32'h7FFFFFFF, res: 32'hFFFFFFFF, freq: 24'd1000000, samp: 32'h7FFFFFFF};
        pending_samples.push_back(d);
        d = '{g4: 32'h80000000, g3: 32'h80000000, g2: 32'h80000000, g1: 32'h80000000,
              g0: 32'h80000000, res: 32'h00000000, freq: 24'd1, samp: 32'h7FFFFFFF};
        pending_samples.push_back(d);
        d = '{g4: 32'hFFFFFFFF, g3: 32'h55555555, g2: 32'hAAAAAAAA, g1: 32'h0,
              g0: 32'h0, res: 32'h01000000, freq: 24'hAAAAAA, samp: 32'hFFFFFFFF};
        pending_samples.push_back(d);
        d.freq = 24'h555555;
        d.samp = 32'h00000001;
        pending_samples.push_back(d);
        run_phase(80, 0);

        // Almost linear clip with the widest level, one step per sample.
        write_reg(REG_SAT_LEVEL, 32'h7FFFFFFF);
        write_reg(REG_SAT_RECIP, 32'd1);
        write_reg(REG_OVERSAMPLE, 32'd1);
        run_phase(100, 1);

        // Zero level and reciprocal with no solver step: the pole outputs hold the old state.
        write_reg(REG_SAT_LEVEL, 32'd0);
        write_reg(REG_SAT_RECIP, 32'd0);
        write_reg(REG_OVERSAMPLE, 32'd0);
        run_phase(60, 2);

        // Hard clip at the smallest level, smallest step, oversample above the cap.
        write_reg(REG_SAT_LEVEL, 32'd1);
        write_reg(REG_SAT_RECIP, 32'hFFFFFFFF);
        write_reg(REG_STEP_SIZE, 32'd1);
        write_reg(REG_OVERSAMPLE, 32'd15);
        run_phase(20, 3);

        // Largest step: the per-step coefficient saturates.
        write_reg(REG_SAT_LEVEL, 32'(RST_SAT_LEVEL));
        write_reg(REG_SAT_RECIP, 32'(RST_SAT_RECIP));
        write_reg(REG_STEP_SIZE, 32'hFFFFFFFF);
        write_reg(REG_OVERSAMPLE, 32'd1);
        run_phase(80, 0);

        write_reg(REG_STEP_SIZE, 32'h00100000);
        write_reg(REG_OVERSAMPLE, 32'(MAX_OVERSAMPLE));
        run_phase(20, 1);

        write_reg(REG_STEP_SIZE, RST_STEP_SIZE);
        write_reg(REG_OVERSAMPLE, 32'(RST_OVERSAMPLE));
        run_phase(100, 2);

        write_reg(REG_SAT_LEVEL, $urandom_range(100000000, 1000000));
        write_reg(REG_SAT_RECIP, $urandom_range(20000000, 200000));
        write_reg(REG_STEP_SIZE, $urandom_range(400000, 1000));
        write_reg(REG_OVERSAMPLE, 32'd3);
        run_phase(70, 3);

        repeat (50) @(posedge i_clk);
        $display("Sent %0d samples and checked %0d outputs over %0d cycles,", n_sent,
                 n_checked, n_cycles);
        $display("covering clip levels, step sizes and oversample counts 0 to 15.");
        if (n_errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hdl/lrk_pkg.sv
hdl/lrk_mul.sv
hdl/ladder_lowpass_rk4_filter.sv
verif/tb_ladder_lowpass_rk4_filter.sv
